// File: rtl/polyval_universal_hash_core_macros.svh
// Assertion macros used by the hash core sequencer (pvh_ctrl).
// Each macro expects signals named clk and arst_n in the enclosing module.
`ifndef POLYVAL_UNIVERSAL_HASH_CORE_MACROS_SVH
`define POLYVAL_UNIVERSAL_HASH_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PVH_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PVH_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/pvh_pkg.sv
package pvh_pkg;

	// Key and accumulator geometry.
	localparam int LANE_W     = 64;
	localparam int BLOCK_W    = 2 * LANE_W;
	localparam int PROD_W     = 2 * BLOCK_W;
	localparam int DIGIT_W    = 16;
	localparam int NUM_DIGITS = BLOCK_W / DIGIT_W;
	localparam int CNT_W      = $clog2(NUM_DIGITS);

	// Configuration register map.
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 2'd1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic             load;
		logic             mul;
		logic [CNT_W-1:0] digit;
		logic             finish;
	} pvh_cmd_t;

endpackage

// File: rtl/pvh_ctrl.sv
module pvh_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	output pvh_pkg::pvh_cmd_t cmd
);
	import pvh_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_RED
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;
	logic             out_free;

	// The result register can take a new value when empty or being drained.
	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	// Command decode from the current state.
	always_comb begin
		cmd.load   = in_valid && (state_q == ST_IDLE);
		cmd.mul    = (state_q == ST_MUL);
		cmd.digit  = cnt_q;
		cmd.finish = (state_q == ST_RED) && out_free;
	end

	// Sequencer: load, eight multiply digits, then reduce into the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// The result register fills on finish and empties on a transfer.
			if ((state_q == ST_RED) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_MUL;
						cnt_q   <= '0;
					end
				end
				ST_MUL: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(NUM_DIGITS - 1)) begin
						state_q <= ST_RED;
					end
				end
				ST_RED: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`include "polyval_universal_hash_core_macros.svh"

	`PVH_ASSERT_NEXT(a_load_starts_mul, cmd.load, (state_q == ST_MUL) && (cnt_q == '0), "load did not start the multiply at digit zero")
	`PVH_ASSERT_NEXT(a_last_digit_reduces, (state_q == ST_MUL) && (cnt_q == CNT_W'(NUM_DIGITS - 1)), state_q == ST_RED, "last digit not followed by reduction")
	`PVH_ASSERT_NEXT(a_finish_sets_valid, cmd.finish, out_valid_q && (state_q == ST_IDLE), "finished result not presented")
	`PVH_ASSERT_NOW(a_one_command, cmd.load || cmd.mul || cmd.finish, $onehot({cmd.load, cmd.mul, cmd.finish}), "more than one datapath command at once")

endmodule

// File: rtl/pvh_datapath.sv
module pvh_datapath (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         write_en,
	input  logic [pvh_pkg::CFG_IDX_W-1:0] write_index,
	input  logic [pvh_pkg::LANE_W-1:0]    write_data,
	input  logic [pvh_pkg::LANE_W-1:0]    block_low,
	input  logic [pvh_pkg::LANE_W-1:0]    block_high,
	input  logic                         restart,
	input  pvh_pkg::pvh_cmd_t             cmd,
	output logic [pvh_pkg::LANE_W-1:0]    digest_low,
	output logic [pvh_pkg::LANE_W-1:0]    digest_high
);
	import pvh_pkg::*;

	localparam int PART_W = BLOCK_W + DIGIT_W;

	logic [BLOCK_W-1:0] key_q;
	logic [BLOCK_W-1:0] sum_q;
	logic [BLOCK_W-1:0] op_q;
	logic [PROD_W-1:0]  prod_q;
	logic [BLOCK_W-1:0] digest_q;

	logic [DIGIT_W-1:0] digit;
	logic [PART_W-1:0]  part;
	logic [BLOCK_W-1:0] seed;
	logic [LANE_W-1:0]  p0, p1, p2, p3;
	logic [LANE_W-1:0]  t0, t1, m0, m1, u0, u1;
	logic [BLOCK_W-1:0] reduced;

	// Carry-less product of the operand with one key digit.
	function automatic logic [PART_W-1:0] clmul_digit(
		input logic [BLOCK_W-1:0] a,
		input logic [DIGIT_W-1:0] b
	);
		logic [PART_W-1:0] acc;
		acc = '0;
		for (int i = 0; i < DIGIT_W; i++) begin
			if (b[i]) begin
				acc = acc ^ ({{DIGIT_W{1'b0}}, a} << i);
			end
		end
		return acc;
	endfunction

	// Hash key registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (write_en) begin
			case (write_index)
				REG_KEY_LOW:  key_q[LANE_W-1:0]       <= write_data;
				REG_KEY_HIGH: key_q[BLOCK_W-1:LANE_W] <= write_data;
				default: ;
			endcase
		end
	end

	// Absorb the block into the (optionally cleared) accumulator.
	assign seed = (restart ? '0 : sum_q) ^ {block_high, block_low};

	// Key digit for this step, least significant first.
	assign digit = key_q[{cmd.digit, 4'b0000} +: DIGIT_W];
	assign part  = clmul_digit(op_q, digit);

	// Multiply operand and product accumulator. Each partial product enters at the
	// top and the accumulator shifts down one digit per step, so digit k ends at 16k.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= seed;
			prod_q <= '0;
		end else if (cmd.mul) begin
			prod_q <= {{DIGIT_W{1'b0}}, prod_q[PROD_W-1:DIGIT_W]}
				^ {part, {(PROD_W - PART_W){1'b0}}};
		end
	end

	// Two-step Montgomery reduction; the constant has bits 63, 62 and 57 set.
	always_comb begin
		p0 = prod_q[LANE_W-1:0];
		p1 = prod_q[2*LANE_W-1:LANE_W];
		p2 = prod_q[3*LANE_W-1:2*LANE_W];
		p3 = prod_q[4*LANE_W-1:3*LANE_W];
		t0 = (p0 << 63) ^ (p0 << 62) ^ (p0 << 57);
		t1 = (p0 >> 1) ^ (p0 >> 2) ^ (p0 >> 7);
		m0 = p1 ^ t0;
		m1 = p0 ^ t1;
		u0 = (m0 << 63) ^ (m0 << 62) ^ (m0 << 57);
		u1 = (m0 >> 1) ^ (m0 >> 2) ^ (m0 >> 7);
		reduced = {m0 ^ u1 ^ p3, m1 ^ u0 ^ p2};
	end

	// Running accumulator.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (cmd.finish) begin
			sum_q <= reduced;
		end
	end

	// Result register, held while the receiver stalls.
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			digest_q <= reduced;
		end
	end

	assign digest_low  = digest_q[LANE_W-1:0];
	assign digest_high = digest_q[BLOCK_W-1:LANE_W];

endmodule

// File: rtl/polyval_universal_hash_core.sv
// POLYVAL universal hash core.
// Input channel (in_valid/in_ready) carries one 16-byte block as two little-endian
// 64-bit words plus a restart flag that clears the accumulator before absorbing it.
// Output channel (out_valid/out_ready) returns the updated 128-bit accumulator for
// every block, in order. The key H is written through write_en/write_index/write_data
// (index 0 low word, index 1 high word). The user must write the key only while
// the core is idle; the core itself does not enforce this. The 128x128 carry-less
// multiply runs as eight 16-bit key digits on one shared unit, followed by a
// reduction step, and a new block is taken only after the core has returned to idle.
// The result sits in an output register: if the receiver stalls, the core still
// takes and multiplies the next block, and waits only in its reduction cycle
// until the previous result has been transferred.
// Reset clears the key, the accumulator and all handshake state.
module polyval_universal_hash_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         write_en,
	input  logic [pvh_pkg::CFG_IDX_W-1:0] write_index,
	input  logic [pvh_pkg::LANE_W-1:0]    write_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [pvh_pkg::LANE_W-1:0]    block_low,
	input  logic [pvh_pkg::LANE_W-1:0]    block_high,
	input  logic                         restart,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [pvh_pkg::LANE_W-1:0]    digest_low,
	output logic [pvh_pkg::LANE_W-1:0]    digest_high
);
	import pvh_pkg::*;

	pvh_cmd_t cmd;

	// Sequencer.
	pvh_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	// Key, accumulator, digit-serial multiplier and reduction.
	pvh_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.write_en    (write_en),
		.write_index (write_index),
		.write_data  (write_data),
		.block_low   (block_low),
		.block_high  (block_high),
		.restart     (restart),
		.cmd         (cmd),
		.digest_low  (digest_low),
		.digest_high (digest_high)
	);

endmodule
